@@ hdl/pow_pkg.sv @@
// shared types and constants for the permutation orbit walker
// no dependencies; imported by every module of the block
package pow_pkg;

    localparam int PT_W     = 18;
    localparam int SIZE_W   = 19;
    localparam int GIDX_W   = 3;
    localparam int GSEL_W   = 4;
    localparam int GCNT_W   = 4;
    localparam int CFG_W    = 19;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_GEN_COUNT   = 1'b1;

    localparam logic [CFG_W-1:0]  PC_RESET = 19'd262144;
    localparam logic [GCNT_W-1:0] GC_RESET = 4'd1;

    typedef struct packed {
        logic              en;
        logic [GSEL_W-1:0] gen;
        logic [PT_W-1:0]   point;
        logic [PT_W-1:0]   image;
    } t_tab_wr;

    typedef struct packed {
        logic              en;
        logic [GSEL_W-1:0] gen;
        logic [PT_W-1:0]   point;
    } t_tab_rd;

    typedef struct packed {
        logic [SIZE_W-1:0] reach_count;
        logic              bad_start;
        logic              bad_image;
    } t_walk_res;

endpackage

@@ hdl/pow_gen_tables.sv @@
// generator table memory: load writes and walk reads, registered read data
// depends on pow_pkg
module pow_gen_tables
    import pow_pkg::*;
#(
    parameter int MAX_POINTS     = 262144,
    parameter int MAX_GENERATORS = 8
) (
    input  logic            i_clk,
    input  t_tab_wr         i_wr,
    input  t_tab_rd         i_rd,
    output logic [PT_W-1:0] o_rd_data
);

    localparam int PW    = $clog2(MAX_POINTS);
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int CW    = (NW > PT_W) ? NW : PT_W;
    localparam int GW    = (MAX_GENERATORS > 1) ? $clog2(MAX_GENERATORS) : 1;
    localparam int DEPTH = 1 << (GW + PW);

    logic [PT_W-1:0]    r_table [DEPTH];
    logic [PT_W-1:0]    r_rd_data;
    logic               wr_ok;
    logic [GW+PW-1:0]   wr_addr;
    logic [GW+PW-1:0]   rd_addr;

    // loads outside the table space are dropped
    assign wr_ok = i_wr.en
                && (5'(i_wr.gen) < 5'(MAX_GENERATORS))
                && (CW'(i_wr.point) < CW'(MAX_POINTS));
    assign wr_addr = {GW'(i_wr.gen), PW'(i_wr.point)};
    assign rd_addr = {GW'(i_rd.gen), PW'(i_rd.point)};

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_table[wr_addr] <= i_wr.image;
        end
        if (i_rd.en) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/pow_walker.sv @@
// walk sequencer with visited map, walk queue and one shared comparator
// depends on pow_pkg; reads the generator tables through a t_tab_rd request
module pow_walker
    import pow_pkg::*;
#(
    parameter int MAX_POINTS     = 262144,
    parameter int MAX_GENERATORS = 8,
    localparam int NW  = $clog2(MAX_POINTS + 1),
    localparam int GCW = $clog2(MAX_GENERATORS + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [PT_W-1:0] i_start_point,
    input  logic [NW-1:0]   i_n,
    input  logic [GCW-1:0]  i_ng,
    output logic            o_idle,
    output t_tab_rd         o_tab_rd,
    input  logic [PT_W-1:0] i_tab_data,
    output logic            o_done,
    output t_walk_res       o_res,
    input  logic            i_res_ack
);

    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = (NW > PT_W) ? NW : PT_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_LATCH = 4'd4;
    localparam logic [3:0] S_GEN   = 4'd5;
    localparam logic [3:0] S_RANGE = 4'd6;
    localparam logic [3:0] S_VISIT = 4'd7;
    localparam logic [3:0] S_SWEEP = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]      r_state, n_state;
    logic [NW-1:0]   r_head, n_head;
    logic [NW-1:0]   r_tail, n_tail;
    logic [NW-1:0]   r_clr, n_clr;
    logic [GCW-1:0]  r_g, n_g;
    logic [PT_W-1:0] r_v, n_v;
    logic [PT_W-1:0] r_w, n_w;
    logic [PT_W-1:0] r_pt, n_pt;
    logic            r_pend, n_pend;
    logic            r_bad_img, n_bad_img;
    logic            r_bad_start, n_bad_start;

    logic            r_visited [MAX_POINTS];
    logic [PT_W-1:0] r_queue [MAX_POINTS];
    logic            r_vis_rd;
    logic [PT_W-1:0] r_q_rd;

    logic            vis_we, vis_wd, vis_re;
    logic [PW-1:0]   vis_wa, vis_ra;
    logic            q_we, q_re;
    logic [PW-1:0]   q_wa, q_ra;
    logic [PT_W-1:0] q_wd;
    logic            tab_re;

    logic [CW-1:0]   cmp_a, cmp_b;
    logic            cmp_lt;

    // shared comparator, operands chosen by state
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (r_state)
            S_START: begin
                cmp_a = CW'(r_pt);
                cmp_b = CW'(i_n);
            end
            S_POP: begin
                cmp_a = CW'(r_head);
                cmp_b = CW'(r_tail);
            end
            S_GEN: begin
                cmp_a = CW'(r_g);
                cmp_b = CW'(i_ng);
            end
            S_RANGE: begin
                cmp_a = CW'(i_tab_data);
                cmp_b = CW'(i_n);
            end
            S_SWEEP: begin
                cmp_a = CW'(r_clr);
                cmp_b = CW'(r_tail);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt = cmp_a < cmp_b;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_clr       = r_clr;
        n_g         = r_g;
        n_v         = r_v;
        n_w         = r_w;
        n_pt        = r_pt;
        n_pend      = r_pend;
        n_bad_img   = r_bad_img;
        n_bad_start = r_bad_start;
        vis_we      = 1'b0;
        vis_wa      = '0;
        vis_wd      = 1'b0;
        vis_re      = 1'b0;
        vis_ra      = '0;
        q_we        = 1'b0;
        q_wa        = '0;
        q_wd        = '0;
        q_re        = 1'b0;
        q_ra        = '0;
        tab_re      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                vis_we = 1'b1;
                vis_wa = r_clr[PW-1:0];
                if (r_clr == NW'(MAX_POINTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_pt    = i_start_point;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_head    = '0;
                n_bad_img = 1'b0;
                if (cmp_lt) begin
                    vis_we      = 1'b1;
                    vis_wa      = PW'(r_pt);
                    vis_wd      = 1'b1;
                    q_we        = 1'b1;
                    q_wd        = r_pt;
                    n_tail      = NW'(1);
                    n_bad_start = 1'b0;
                    n_state     = S_POP;
                end else begin
                    n_tail      = '0;
                    n_bad_start = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_POP: begin
                if (cmp_lt) begin
                    q_re    = 1'b1;
                    q_ra    = r_head[PW-1:0];
                    n_head  = r_head + 1'b1;
                    n_g     = '0;
                    n_state = S_LATCH;
                end else begin
                    n_clr   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SWEEP;
                end
            end
            S_LATCH: begin
                n_v     = r_q_rd;
                n_state = S_GEN;
            end
            S_GEN: begin
                if (cmp_lt) begin
                    tab_re  = 1'b1;
                    n_g     = r_g + 1'b1;
                    n_state = S_RANGE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_RANGE: begin
                if (cmp_lt) begin
                    vis_re  = 1'b1;
                    vis_ra  = PW'(i_tab_data);
                    n_w     = i_tab_data;
                    n_state = S_VISIT;
                end else begin
                    n_bad_img = 1'b1;
                    n_state   = S_GEN;
                end
            end
            S_VISIT: begin
                if (!r_vis_rd) begin
                    vis_we = 1'b1;
                    vis_wa = PW'(r_w);
                    vis_wd = 1'b1;
                    q_we   = 1'b1;
                    q_wa   = r_tail[PW-1:0];
                    q_wd   = r_w;
                    n_tail = r_tail + 1'b1;
                end
                n_state = S_GEN;
            end
            S_SWEEP: begin
                // visited points are exactly the queue contents
                if (r_pend) begin
                    vis_we = 1'b1;
                    vis_wa = PW'(r_q_rd);
                end
                if (cmp_lt) begin
                    q_re   = 1'b1;
                    q_ra   = r_clr[PW-1:0];
                    n_clr  = r_clr + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g         <= n_g;
        r_v         <= n_v;
        r_w         <= n_w;
        r_pt        <= n_pt;
        r_bad_img   <= n_bad_img;
        r_bad_start <= n_bad_start;
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_visited[vis_wa] <= vis_wd;
        end
        if (vis_re) begin
            r_vis_rd <= r_visited[vis_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[q_wa] <= q_wd;
        end
        if (q_re) begin
            r_q_rd <= r_queue[q_ra];
        end
    end

    assign o_idle          = (r_state == S_IDLE);
    assign o_done          = (r_state == S_DONE);
    assign o_tab_rd.en     = tab_re;
    assign o_tab_rd.gen    = GSEL_W'(r_g);
    assign o_tab_rd.point  = r_v;
    assign o_res.reach_count = SIZE_W'(r_tail);
    assign o_res.bad_start   = r_bad_start;
    assign o_res.bad_image   = r_bad_img;

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VISIT && !r_vis_rd) |-> (CW'(r_w) < CW'(i_n)))
        else $error("out of range image marked");

    a_bad_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_bad_start) |-> (r_tail == '0 && !r_bad_img))
        else $error("bad start result not empty");

    a_range_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANGE) |-> ($past(r_state) == S_GEN && $past(tab_re)))
        else $error("image checked without table read");

endmodule

@@ hdl/permutation_orbit_walker.sv @@
// Orbit walker: a load transfer writes one generator table entry; a start transfer
// runs a breadth-first walk and gives one result.
// The walk is sequenced over single-port memories (tables, visited map, queue)
// with one shared comparator: each dequeued point is expanded over all G generators,
// then the visited map is cleared by a sweep over the queued orbit points.
// Input stall is high for the whole walk.
// After reset the visited map is swept once, before any transfer is accepted;
// configuration writes are taken meanwhile.
// depends on pow_pkg, pow_gen_tables, pow_walker
module permutation_orbit_walker
    import pow_pkg::*;
#(
    parameter int MAX_POINTS     = 262144,
    parameter int MAX_GENERATORS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_command,
    input  logic [GIDX_W-1:0] i_generator_index,
    input  logic [PT_W-1:0]   i_point,
    input  logic [PT_W-1:0]   i_image,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [SIZE_W-1:0] o_reach_count,
    output logic              o_bad_start,
    output logic              o_bad_image
);

    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int GCW = $clog2(MAX_GENERATORS + 1);
    localparam int XW  = (NW > CFG_W) ? NW : CFG_W;

    logic [CFG_W-1:0]  r_point_count;
    logic [GCNT_W-1:0] r_gen_count;
    logic              r_out_valid;
    t_walk_res         r_out;

    logic [NW-1:0]     eff_n;
    logic [GCW-1:0]    eff_ng;
    logic              in_xfer;
    logic              walk_idle;
    logic              walk_done;
    logic              res_ack;
    t_walk_res         walk_res;
    t_tab_wr           tab_wr;
    t_tab_rd           tab_rd;
    logic [PT_W-1:0]   tab_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= PC_RESET;
            r_gen_count   <= GC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POINT_COUNT: r_point_count <= i_cfg_data;
                CFG_GEN_COUNT:   r_gen_count   <= i_cfg_data[GCNT_W-1:0];
                default:         r_gen_count   <= r_gen_count;
            endcase
        end
    end

    assign eff_n  = (XW'(r_point_count) > XW'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                           : NW'(r_point_count);
    assign eff_ng = (5'(r_gen_count) > 5'(MAX_GENERATORS)) ? GCW'(MAX_GENERATORS)
                                                           : GCW'(r_gen_count);

    assign o_in_stall = !walk_idle;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign tab_wr.en    = in_xfer && (i_command == CMD_LOAD);
    assign tab_wr.gen   = GSEL_W'(i_generator_index);
    assign tab_wr.point = i_point;
    assign tab_wr.image = i_image;

    pow_gen_tables #(
        .MAX_POINTS     (MAX_POINTS),
        .MAX_GENERATORS (MAX_GENERATORS)
    ) u_tables (
        .i_clk     (i_clk),
        .i_wr      (tab_wr),
        .i_rd      (tab_rd),
        .o_rd_data (tab_data)
    );

    pow_walker #(
        .MAX_POINTS     (MAX_POINTS),
        .MAX_GENERATORS (MAX_GENERATORS)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_xfer && (i_command == CMD_START)),
        .i_start_point (i_point),
        .i_n           (eff_n),
        .i_ng          (eff_ng),
        .o_idle        (walk_idle),
        .o_tab_rd      (tab_rd),
        .i_tab_data    (tab_data),
        .o_done        (walk_done),
        .o_res         (walk_res),
        .i_res_ack     (res_ack)
    );

    // output register frees the walker as soon as the slot can take a result
    assign res_ack = walk_done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_out <= walk_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_reach_count = r_out.reach_count;
    assign o_bad_start   = r_out.bad_start;
    assign o_bad_image   = r_out.bad_image;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// self-checking bench for permutation_orbit_walker: drives table loads and orbit walks,
// predicts each walk by its own breadth-first search and compares every result transfer
// depends on pow_pkg and the permutation_orbit_walker rtl
module testbench;
    import pow_pkg::*;

    localparam int POINTS_MAX   = 262144;
    localparam int GENS_MAX     = 8;
    localparam int REGION_MAX   = 64;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 400;
    localparam int PC_ALL_ONES  = (1 << CFG_W) - 1;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_idx = CFG_POINT_COUNT;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              command = CMD_LOAD;
    logic [GIDX_W-1:0] generator_index = '0;
    logic [PT_W-1:0]   point = '0;
    logic [PT_W-1:0]   image = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [SIZE_W-1:0] reach_count;
    logic              bad_start;
    logic              bad_image;

    logic [PT_W-1:0]   gen_table [int];
    logic [CFG_W-1:0]  cfg_points = PC_RESET;
    logic [GCNT_W-1:0] cfg_gens = GC_RESET;
    t_walk_res         expected_walks [$];

    int mismatch_count = 0;
    int items_sent = 0;
    int in_gap_pct = 10;
    int out_gap_pct = 10;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    permutation_orbit_walker #(
        .MAX_POINTS     (POINTS_MAX),
        .MAX_GENERATORS (GENS_MAX)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_command         (command),
        .i_generator_index (generator_index),
        .i_point           (point),
        .i_image           (image),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_reach_count     (reach_count),
        .o_bad_start       (bad_start),
        .o_bad_image       (bad_image)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #(30_000_000);
        $display("permutation_orbit_walker: mismatch");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: %s", $time, what);
    endtask

    function automatic int table_key(input int g, input int p);
        return g * POINTS_MAX + p;
    endfunction

    // returns 0 when the walk would read a table entry never loaded
    function automatic bit trace_orbit(input logic [PT_W-1:0] start, output t_walk_res walk);
        bit seen [int];
        int order [$];
        int n, ng, head, v, g, key;
        logic [PT_W-1:0] img;
        n = (cfg_points > POINTS_MAX) ? POINTS_MAX : int'(cfg_points);
        ng = (cfg_gens > GENS_MAX) ? GENS_MAX : int'(cfg_gens);
        walk = '0;
        if (int'(start) >= n) begin
            walk.bad_start = 1'b1;
            return 1'b1;
        end
        seen[int'(start)] = 1'b1;
        order.insert(order.size(), int'(start));
        head = 0;
        while (head < order.size()) begin
            v = order[head];
            head++;
            for (g = 0; g < ng; g++) begin
                key = table_key(g, v);
                if (!gen_table.exists(key)) return 1'b0;
                img = gen_table[key];
                if (int'(img) >= n) begin
                    walk.bad_image = 1'b1;
                end else if (!seen.exists(int'(img)) && order.size() < POINTS_MAX) begin
                    seen[int'(img)] = 1'b1;
                    order.insert(order.size(), int'(img));
                end
            end
        end
        walk.reach_count = SIZE_W'(order.size());
        return 1'b1;
    endfunction

    task automatic send_item(input logic cmd, input logic [GIDX_W-1:0] gi,
                             input logic [PT_W-1:0] pt, input logic [PT_W-1:0] img);
        t_walk_res walk;
        if (!quiet && $urandom_range(1, 100) <= in_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        generator_index <= gi;
        point <= pt;
        image <= img;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        items_sent++;
        if (cmd == CMD_LOAD) begin
            gen_table[table_key(int'(gi), int'(pt))] = img;
        end else begin
            void'(trace_orbit(pt, walk));
            expected_walks.insert(expected_walks.size(), walk);
        end
    endtask

    task automatic start_walk(input logic [PT_W-1:0] pt);
        t_walk_res walk;
        if (trace_orbit(pt, walk)) begin
            send_item(CMD_START, GIDX_W'($urandom), pt, PT_W'($urandom));
        end
    endtask

    task automatic send_noise();
        send_item(CMD_LOAD, GIDX_W'($urandom), PT_W'($urandom), PT_W'($urandom));
    endtask

    function automatic logic [PT_W-1:0] pick_image(input int base, input int region,
                                                   input int bad_pct, input int mapped);
        if ($urandom_range(1, 100) <= bad_pct) return PT_W'($urandom_range(region, POINTS_MAX - 1));
        return PT_W'(base + mapped);
    endfunction

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_walks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POINT_COUNT) begin
            cfg_points = value;
        end else begin
            cfg_gens = value[GCNT_W-1:0];
        end
        @(posedge clk);
    endtask

    // loads the used generators' region entries in shuffled order, all only when fresh
    task automatic fill_region(input int base, input int region, input int gens,
                               input int bad_pct, input bit fresh);
        int perm [GENS_MAX][REGION_MAX];
        int slots [$];
        int g, p, j, tmp, s;
        for (g = 0; g < GENS_MAX; g++) begin
            for (p = 0; p < REGION_MAX; p++) perm[g][p] = p;
            for (p = region - 1; p > 0; p--) begin
                j = $urandom_range(0, p);
                tmp = perm[g][p];
                perm[g][p] = perm[g][j];
                perm[g][j] = tmp;
            end
        end
        for (g = 0; g < gens; g++) begin
            for (p = 0; p < region; p++) slots.insert(slots.size(), g * REGION_MAX + p);
        end
        for (p = slots.size() - 1; p > 0; p--) begin
            j = $urandom_range(0, p);
            tmp = slots[p];
            slots[p] = slots[j];
            slots[j] = tmp;
        end
        foreach (slots[i]) begin
            s = slots[i];
            g = s / REGION_MAX;
            p = s % REGION_MAX;
            if (fresh || !gen_table.exists(table_key(g, base + p)) || $urandom_range(0, 1)) begin
                send_item(CMD_LOAD, GIDX_W'(g), PT_W'(base + p),
                          pick_image(base, region, bad_pct, perm[g][p]));
            end
            if ($urandom_range(1, 100) <= 8) send_noise();
            if ($urandom_range(1, 100) <= 3) start_walk(PT_W'(base + $urandom_range(0, region - 1)));
        end
    endtask

    task automatic walk_starts(input int base, input int region, input int gens,
                               input int bad_pct, input int count);
        t_walk_res walk;
        logic [PT_W-1:0] cand;
        int g, p;
        repeat (count) begin
            if ($urandom_range(1, 100) <= 15) begin
                cand = PT_W'($urandom);
            end else begin
                cand = PT_W'(base + $urandom_range(0, region - 1));
            end
            if (!trace_orbit(cand, walk)) cand = PT_W'(base + $urandom_range(0, region - 1));
            start_walk(cand);
            if ($urandom_range(1, 100) <= 30) begin
                g = $urandom_range(0, gens - 1);
                p = $urandom_range(0, region - 1);
                send_item(CMD_LOAD, GIDX_W'(g), PT_W'(base + p),
                          pick_image(base, region, bad_pct, $urandom_range(0, region - 1)));
            end
            if ($urandom_range(1, 100) <= 10) send_noise();
        end
    endtask

    task automatic test_reset_values();
        send_item(CMD_LOAD, 3'd0, 18'd5, 18'd9);
        send_item(CMD_LOAD, 3'd0, 18'd9, 18'd5);
        send_item(CMD_LOAD, 3'd0, 18'd262143, 18'd262143);
        start_walk(18'd5);
        start_walk(18'd262143);
    endtask

    task automatic test_register_extremes();
        int g, p;
        settle();
        write_reg(CFG_POINT_COUNT, '0);
        start_walk(18'd0);
        settle();
        write_reg(CFG_POINT_COUNT, CFG_W'(PC_ALL_ONES));
        start_walk(18'd262143);
        settle();
        write_reg(CFG_POINT_COUNT, CFG_W'(1));
        write_reg(CFG_GEN_COUNT, '0);
        start_walk(18'd0);
        start_walk(18'd1);
        settle();
        write_reg(CFG_POINT_COUNT, CFG_W'(2));
        write_reg(CFG_GEN_COUNT, CFG_W'(15));
        // last generator swaps the two points, generator 3 throws point 1 out of range
        for (g = 0; g < GENS_MAX; g++) begin
            for (p = 0; p < 2; p++) begin
                send_item(CMD_LOAD, GIDX_W'(g), PT_W'(p),
                          (g == 7) ? PT_W'(1 - p) : (g == 3 && p == 1) ? 18'd262143 : PT_W'(p));
            end
        end
        start_walk(18'd0);
        settle();
        write_reg(CFG_GEN_COUNT, CFG_W'(7));
        start_walk(18'd0);
    endtask

    task automatic test_random_orbits();
        int goal, region, base, gc, gens, pc, bad_pct;
        bit at_top;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            region = ($urandom_range(0, 9) == 0) ? $urandom_range(41, REGION_MAX)
                                                 : $urandom_range(1, 40);
            at_top = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: gc = 0;
                1: gc = $urandom_range(GENS_MAX + 1, 15);
                default: gc = $urandom_range(1, GENS_MAX);
            endcase
            gens = (gc == 0) ? 1 : (gc > GENS_MAX) ? GENS_MAX : gc;
            if (at_top) begin
                base = POINTS_MAX - region;
                case ($urandom_range(0, 2))
                    0: pc = POINTS_MAX;
                    1: pc = PC_ALL_ONES;
                    default: pc = $urandom_range(POINTS_MAX, PC_ALL_ONES);
                endcase
                bad_pct = 0;
            end else begin
                base = 0;
                pc = region;
                bad_pct = $urandom_range(0, 1) ? 5 : 0;
            end
            settle();
            write_reg(CFG_POINT_COUNT, CFG_W'(pc));
            write_reg(CFG_GEN_COUNT, CFG_W'(gc));
            case ($urandom_range(0, 2))
                0: in_gap_pct = 0;
                1: in_gap_pct = 10;
                default: in_gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: out_gap_pct = 0;
                1: out_gap_pct = 4;
                default: out_gap_pct = 15;
            endcase
            fill_region(base, region, gens, bad_pct, at_top);
            walk_starts(base, region, gens, bad_pct, $urandom_range(4, 10));
        end
    endtask

    task automatic test_output_backpressure();
        int p;
        settle();
        write_reg(CFG_POINT_COUNT, CFG_W'(6));
        write_reg(CFG_GEN_COUNT, CFG_W'(3));
        in_gap_pct = 0;
        out_gap_pct = 0;
        fill_region(0, 6, 3, 0, 1'b1);
        hold_req = 1'b1;
        for (p = 0; p < 6; p++) start_walk(PT_W'(p));
    endtask

    task automatic test_no_idle_tail();
        settle();
        quiet = 1'b1;
        write_reg(CFG_POINT_COUNT, CFG_W'(10));
        write_reg(CFG_GEN_COUNT, CFG_W'(5));
        fill_region(0, 10, 5, 5, 1'b1);
        walk_starts(0, 10, 5, 5, 8);
    endtask

    // result side stall, random bursts plus one long hold on request
    initial begin : result_stall_driver
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(1, 100) <= out_gap_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : orbit_checker
        t_walk_res want;
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0) begin
                if (expected_walks.size() == 0) begin
                    flag_mismatch($sformatf("result transfer with none pending, size %0d",
                                            reach_count));
                end else begin
                    want = expected_walks.pop_front();
                    if (reach_count !== want.reach_count || bad_start !== want.bad_start
                            || bad_image !== want.bad_image) begin
                        flag_mismatch($sformatf(
                            "size %0d exp %0d, bad_start %b exp %b, bad_image %b exp %b",
                            reach_count, want.reach_count, bad_start, want.bad_start,
                            bad_image, want.bad_image));
                    end
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_register_extremes();
        test_random_orbits();
        test_output_backpressure();
        test_no_idle_tail();
        settle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("permutation_orbit_walker: match");
        end else begin
            $display("permutation_orbit_walker: mismatch");
        end
        $finish;
    end

endmodule
